// ===== src/bsic_pkg.sv =====
// bsic_pkg: shared types, constants and the digit adjust function of the
// shift-in binary to packed-bcd converter. No dependencies.

package bsic_pkg;

    localparam int NUM_WORDS  = 4;
    localparam int READ_WORDS = (NUM_WORDS < 4) ? NUM_WORDS : 4;
    localparam int WORD_W     = 64;
    localparam int DIGITS     = WORD_W / 4;

    typedef enum logic [1:0] {
        CMD_CLEAR = 2'd0,
        CMD_STEP  = 2'd1,
        CMD_READ  = 2'd2,
        CMD_LOAD  = 2'd3
    } t_cmd;

    typedef logic [WORD_W-1:0] t_word;

    typedef struct packed {
        t_cmd       cmd;
        logic       bit_in;
        logic [1:0] word_index;
        t_word      load_word;
    } t_in_item;

    typedef struct packed {
        t_word      bcd_word;
        logic [1:0] out_index;
        logic       last;
        logic       overflowed;
    } t_out_item;

    // every digit above 4 gets 3 added, wrapping inside the digit
    function automatic t_word digit_adjust(input t_word w);
        t_word      r;
        logic [3:0] d;
        r = '0;
        for (int k = 0; k < DIGITS; k++) begin
            d = w[k*4 +: 4];
            if (d > 4'd4) begin
                d = d + 4'd3;
            end
            r[k*4 +: 4] = d;
        end
        return r;
    endfunction

endpackage

// ===== src/bsic_if.sv =====
// bsic_in_if / bsic_out_if: valid-ready channels of the converter.
// Depend on bsic_pkg for the payload types.

interface bsic_in_if;
    import bsic_pkg::*;
    logic     valid;
    logic     ready;
    t_in_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface bsic_out_if;
    import bsic_pkg::*;
    logic      valid;
    logic      ready;
    t_out_item data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== src/bcd_shift_in_converter.sv =====
// bcd_shift_in_converter: packed-bcd accumulator with double dabble step,
// clear, word load and read out. Depends on bsic_pkg and bsic_if.
//
//  channel | dir | payload                                   | notes
//  i_in    | in  | cmd, bit_in, word_index, load_word        | one item per cycle while ready
//  o_out   | out | bcd_word, out_index, last, overflowed     | READ_WORDS items per read
//
// clear, step and load finish at the accepting edge.
// a read copies the first READ_WORDS words into an output snapshot, which then
// gives one word per cycle that o_out.ready is high.
// while the snapshot is busy, other commands are still taken; a new read waits
// until the last word of the previous one leaves.
// i_rst_n is synchronous, active low, and clears the store, the flag and the read out control.

module bcd_shift_in_converter
    import bsic_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    bsic_in_if.sink     i_in,
    bsic_out_if.source  o_out
);

    t_word      r_store [NUM_WORDS];
    logic       r_ovf;
    t_word      r_snap  [READ_WORDS];
    logic       r_snap_ovf;
    logic       r_out_busy;
    logic [1:0] r_out_cnt;

    t_word      w_adj   [NUM_WORDS];
    logic       w_last;
    logic       w_out_take;
    logic       w_snap_free;
    logic       w_accept;
    t_in_item   w_item;

    assign w_item      = i_in.data;
    assign w_last      = (r_out_cnt == 2'(READ_WORDS - 1));
    assign w_out_take  = r_out_busy && o_out.ready;
    assign w_snap_free = !r_out_busy || (o_out.ready && w_last);
    assign i_in.ready  = (w_item.cmd != CMD_READ) || w_snap_free;
    assign w_accept    = i_in.valid && i_in.ready;

    always_comb begin
        for (int w = 0; w < NUM_WORDS; w++) begin
            w_adj[w] = digit_adjust(r_store[w]);
        end
    end

    // accumulator and sticky overflow flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int w = 0; w < NUM_WORDS; w++) begin
                r_store[w] <= '0;
            end
            r_ovf <= 1'b0;
        end else if (w_accept) begin
            unique case (w_item.cmd)
                CMD_CLEAR: begin
                    for (int w = 0; w < NUM_WORDS; w++) begin
                        r_store[w] <= '0;
                    end
                    r_ovf <= 1'b0;
                end
                CMD_STEP: begin
                    // carry into each word above word 0 is the top bit of the adjusted word below; word 0 takes bit_in
                    r_store[0] <= {w_adj[0][WORD_W-2:0], w_item.bit_in};
                    for (int w = 1; w < NUM_WORDS; w++) begin
                        r_store[w] <= {w_adj[w][WORD_W-2:0], w_adj[w-1][WORD_W-1]};
                    end
                    if (w_adj[NUM_WORDS-1][WORD_W-1]) begin
                        r_ovf <= 1'b1;
                    end
                end
                CMD_LOAD: begin
                    for (int w = 0; w < NUM_WORDS; w++) begin
                        if (32'(w_item.word_index) == 32'(w)) begin
                            r_store[w] <= w_item.load_word;
                        end
                    end
                end
                CMD_READ: begin
                end
                default: begin
                end
            endcase
        end
    end

    // read out control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_busy <= 1'b0;
            r_out_cnt  <= '0;
        end else if (w_accept && w_item.cmd == CMD_READ) begin
            r_out_busy <= 1'b1;
            r_out_cnt  <= '0;
        end else if (w_out_take) begin
            r_out_busy <= !w_last;
            r_out_cnt  <= r_out_cnt + 2'd1;
        end
    end

    // snapshot words, shifted down as each one is taken
    always_ff @(posedge i_clk) begin
        if (w_accept && w_item.cmd == CMD_READ) begin
            for (int k = 0; k < READ_WORDS; k++) begin
                r_snap[k] <= r_store[k];
            end
            r_snap_ovf <= r_ovf;
        end else if (w_out_take) begin
            for (int k = 0; k < READ_WORDS - 1; k++) begin
                r_snap[k] <= r_snap[k+1];
            end
        end
    end

    assign o_out.valid           = r_out_busy;
    assign o_out.data.bcd_word   = r_snap[0];
    assign o_out.data.out_index  = r_out_cnt;
    assign o_out.data.last       = w_last;
    assign o_out.data.overflowed = r_snap_ovf;

`ifndef SYNTHESIS
    a_read_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_item.cmd == CMD_READ) |=> (r_out_busy && r_out_cnt == 2'd0))
        else $error("read out did not start at word zero");

    a_ovf_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovf && !(w_accept && w_item.cmd == CMD_CLEAR)) |=> r_ovf)
        else $error("overflow flag dropped without a clear");

    a_stall_only_when_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> (r_out_busy && w_item.cmd == CMD_READ))
        else $error("input stalled without a pending read out");

    a_cnt_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_busy |-> (32'(r_out_cnt) < READ_WORDS))
        else $error("read out index beyond the snapshot");
`endif

endmodule
